[rtl/core/fastq_record_parser_assert.svh]
// Assertion macros used by the checker file.
`ifndef FASTQ_RECORD_PARSER_ASSERT_SVH
`define FASTQ_RECORD_PARSER_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define FQP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked property that also holds while reset is asserted.
`define FQP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/core/fqp_pkg.sv]
// ----------------------------------------------------------------------------
// fqp_pkg
// Shared types and constants for the FASTQ record parser.
// ----------------------------------------------------------------------------
package fqp_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SEEK  = 3'd0,
    PH_SKIP1 = 3'd1,
    PH_HDR   = 3'd2,
    PH_SEQ   = 3'd3,
    PH_SKIP2 = 3'd4,
    PH_PLUS  = 3'd5,
    PH_QUAL  = 3'd6
  } phase_e;

  // Result word kinds
  typedef enum logic [2:0] {
    KIND_HDR   = 3'd0,
    KIND_SEQ   = 3'd1,
    KIND_PLUS  = 3'd2,
    KIND_QUAL  = 3'd3,
    KIND_DONE  = 3'd4,
    KIND_NONE  = 3'd5,
    KIND_TRUNC = 3'd6,
    KIND_LOW   = 3'd7
  } kind_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_ENCODING = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_Q    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_Q    = 2'd2;

  // Reset values
  localparam logic       RstEncoding = 1'b0;
  localparam logic [7:0] RstMinQ     = 8'd48;
  localparam logic [7:0] RstMaxQ     = 8'd108;

  // Characters
  localparam logic [7:0] ChAt      = 8'h40;  // '@'
  localparam logic [7:0] ChBang    = 8'h21;  // '!'
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0d;

  // Configuration bundle
  typedef struct packed {
    logic       encoding;
    logic [7:0] min_q;
    logic [7:0] max_q;
  } cfg_t;

  // Outcome of one parse step
  typedef struct packed {
    logic       emit;
    kind_e      kind;
    logic [7:0] value;
    phase_e     phase;
  } step_t;

endpackage

[rtl/core/fqp_cfg.sv]
// ----------------------------------------------------------------------------
// fqp_cfg
// Configuration register file: encoding select and quality code range.
// ----------------------------------------------------------------------------
module fqp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [fqp_pkg::CfgIdxW-1:0]    wr_index_i,
  input  logic [7:0]                     wr_data_i,
  output fqp_pkg::cfg_t                  cfg_o
);

  fqp_pkg::cfg_t cfg_q, cfg_d;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        fqp_pkg::REG_ENCODING: cfg_d.encoding = wr_data_i[0];
        fqp_pkg::REG_MIN_Q:    cfg_d.min_q    = wr_data_i;
        fqp_pkg::REG_MAX_Q:    cfg_d.max_q    = wr_data_i;
        default:               cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.encoding <= fqp_pkg::RstEncoding;
      cfg_q.min_q    <= fqp_pkg::RstMinQ;
      cfg_q.max_q    <= fqp_pkg::RstMaxQ;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/fqp_step.sv]
// ----------------------------------------------------------------------------
// fqp_step
// One parse step: next phase and optional result word for one input word.
// ----------------------------------------------------------------------------
module fqp_step (
  input  fqp_pkg::phase_e phase_i,
  input  logic [7:0]      byte_i,
  input  logic            eoi_i,
  input  fqp_pkg::cfg_t   cfg_i,
  output fqp_pkg::step_t  step_o
);

  fqp_pkg::phase_e  ph_eff;
  logic             skip_space;
  logic             is_nl;
  logic             is_ws;
  logic [7:0]       offset;
  logic signed [9:0] qual;
  logic signed [9:0] lim;
  logic [7:0]       qual_code;

  assign is_nl = (byte_i == fqp_pkg::ChNewline);
  assign is_ws = (byte_i == fqp_pkg::ChSpace) ||
                 ((byte_i >= fqp_pkg::ChTab) && (byte_i <= fqp_pkg::ChCr));

  // Leading spaces fold into the line that follows them
  always_comb begin
    skip_space = 1'b0;
    ph_eff     = phase_i;
    case (phase_i)
      fqp_pkg::PH_SKIP1: begin
        skip_space = (byte_i == fqp_pkg::ChSpace);
        ph_eff     = fqp_pkg::PH_HDR;
      end
      fqp_pkg::PH_SKIP2: begin
        skip_space = (byte_i == fqp_pkg::ChSpace);
        ph_eff     = fqp_pkg::PH_PLUS;
      end
      default: ph_eff = phase_i;
    endcase
  end

  // Quality rebase and saturation
  assign offset    = cfg_i.encoding ? fqp_pkg::ChBang : fqp_pkg::ChAt;
  assign qual      = $signed({2'b00, byte_i}) - $signed({2'b00, offset});
  assign lim       = $signed({2'b00, cfg_i.max_q}) - $signed({2'b00, cfg_i.min_q});
  assign qual_code = (qual > lim) ? cfg_i.max_q : (qual[7:0] + cfg_i.min_q);

  // Phase transition and result
  always_comb begin
    step_o.emit  = 1'b0;
    step_o.kind  = fqp_pkg::KIND_HDR;
    step_o.value = byte_i;
    step_o.phase = phase_i;
    if (eoi_i) begin
      step_o.emit  = 1'b1;
      step_o.value = 8'd0;
      step_o.phase = fqp_pkg::PH_SEEK;
      case (phase_i)
        fqp_pkg::PH_SKIP1,
        fqp_pkg::PH_HDR,
        fqp_pkg::PH_SEQ:   step_o.kind = fqp_pkg::KIND_TRUNC;
        fqp_pkg::PH_SKIP2,
        fqp_pkg::PH_PLUS,
        fqp_pkg::PH_QUAL:  step_o.kind = fqp_pkg::KIND_DONE;
        default:           step_o.kind = fqp_pkg::KIND_NONE;
      endcase
    end else if (!skip_space) begin
      case (ph_eff)
        fqp_pkg::PH_HDR: begin
          step_o.phase = is_nl ? fqp_pkg::PH_SEQ : fqp_pkg::PH_HDR;
          step_o.emit  = !is_nl;
          step_o.kind  = fqp_pkg::KIND_HDR;
        end
        fqp_pkg::PH_SEQ: begin
          step_o.phase = is_nl ? fqp_pkg::PH_SKIP2 : fqp_pkg::PH_SEQ;
          step_o.emit  = !is_ws;
          step_o.kind  = fqp_pkg::KIND_SEQ;
        end
        fqp_pkg::PH_PLUS: begin
          step_o.phase = is_nl ? fqp_pkg::PH_QUAL : fqp_pkg::PH_PLUS;
          step_o.emit  = !is_nl;
          step_o.kind  = fqp_pkg::KIND_PLUS;
        end
        fqp_pkg::PH_QUAL: begin
          step_o.emit = 1'b1;
          if (is_nl) begin
            step_o.phase = fqp_pkg::PH_SEEK;
            step_o.kind  = fqp_pkg::KIND_DONE;
            step_o.value = 8'd0;
          end else if (qual < 0) begin
            step_o.phase = fqp_pkg::PH_SEEK;
            step_o.kind  = fqp_pkg::KIND_LOW;
          end else begin
            step_o.kind  = fqp_pkg::KIND_QUAL;
            step_o.value = qual_code;
          end
        end
        default: begin
          // Seek: wait for the record marker
          step_o.phase = (byte_i == fqp_pkg::ChAt) ? fqp_pkg::PH_SKIP1 : fqp_pkg::PH_SEEK;
        end
      endcase
    end
  end

endmodule

[rtl/core/fastq_record_parser.sv]
// ----------------------------------------------------------------------------
// fastq_record_parser
// Streaming FASTQ parser: tags header, sequence, plus and quality bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per cycle while
//   in_stall_o is low: a file byte or an end-of-input mark. Output channel
//   (out_valid_o / out_stall_i) carries at most one result word per input
//   word: a tagged byte, a converted quality code, a record status or a
//   low-quality error. Words that are skipped (bytes before '@', spaces,
//   line ends other than the quality line end) give none. Each accepted
//   word passes through the input register, then through the phase logic
//   into the output register. Throughput is one word per cycle unless the
//   receiver stalls, set by the phase update into the output register.
//   When the receiver stalls, the result holds and one more word waits in
//   the input register; after that in_stall_o rises in the same cycle.
//   Configuration writes (cfg_valid_i with cfg_index_i, cfg_data_i) are
//   always ready and must only be issued while the parser is idle.
//   Reset clears the phase to record seek, empties both registers and
//   restores encoding '@', min code 48 and max code 108.
// ----------------------------------------------------------------------------
module fastq_record_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  in_byte_i,
  input  logic                        end_of_input_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  kind_o,
  output logic [7:0]                  value_o,
  // configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fqp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);

  fqp_pkg::cfg_t   cfg;
  fqp_pkg::step_t  step;
  fqp_pkg::phase_e phase_q;

  logic       in_acc;
  logic       s1_adv;
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_eoi_q;
  logic       out_valid_q, out_valid_d;
  logic [2:0] out_kind_q;
  logic [7:0] out_value_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  fqp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: input register advances unless the result is held
  assign s1_adv     = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? step.emit :
                       ((out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_byte_i;
      s1_eoi_q  <= end_of_input_i;
    end
  end

  // Parse step
  fqp_step u_step (
    .phase_i (phase_q),
    .byte_i  (s1_byte_q),
    .eoi_i   (s1_eoi_q),
    .cfg_i   (cfg),
    .step_o  (step)
  );

  // Phase and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fqp_pkg::PH_SEEK;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        phase_q <= step.phase;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (s1_adv && step.emit) begin
      out_kind_q  <= step.kind;
      out_value_q <= step.value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign value_o     = out_value_q;

endmodule

[rtl/core/fqp_checker.sv]
// ----------------------------------------------------------------------------
// fqp_checker
// Port-level assertions for the FASTQ record parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "fastq_record_parser_assert.svh"

module fqp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] kind_o,
  input logic [7:0] value_o
);

  // A held result keeps its word
  `FQP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(value_o), "result word changed while stalled")

  // Input is only back-pressured by a held result
  `FQP_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> out_valid_o, "input stalled with no pending result")

  // Status words carry a zero value
  `FQP_ASSERT(a_status_zero, out_valid_o && (kind_o == fqp_pkg::KIND_DONE || kind_o == fqp_pkg::KIND_NONE || kind_o == fqp_pkg::KIND_TRUNC) |-> value_o == 8'd0, "status word with nonzero value")

  // A new result follows an accepted input word
  `FQP_ASSERT(a_no_invent, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2), "result without accepted input")

endmodule

bind fastq_record_parser fqp_checker u_fqp_checker (.*);
